// File: hw/rtl/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher block.
// Used by rc4_ctrl, rc4_datapath and the rc4_stream_cipher top level.
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;

  // Datapath commands, issued by the controller
  typedef struct packed {
    logic key_load;     // store key byte (if room) and bump the length
    logic sched_begin;  // clear p, j, k before the key schedule
    logic init_wr;      // write S[p] = p, advance p
    logic sch_rd_j;     // j += S[p] + key[k], read S[j]
    logic sch_wr_i;     // S[p] = S[j]
    logic sch_wr_j;     // S[j] = old S[p], advance p and k
    logic sched_done;   // clear i, j and the length, mark keyed
    logic ks_start;     // latch data byte, i += 1, read S[i]
    logic ks_rd_j;      // j += S[i], read S[j]
    logic ks_wr_i;      // S[i] = S[j], read S[S[i] + S[j]]
    logic ks_wr_j;      // S[j] = old S[i]
    logic pass_load;    // latch data byte for an unkeyed transfer
    logic ks_hold;      // park the keystream byte while output is busy
    logic out_load_ks;  // load output from the live keystream byte
    logic out_load_reg; // load output from the parked values
  } rc4_cmd_t;

  typedef struct packed {
    logic keyed;   // a key schedule has completed
    logic p_last;  // position counter is at the last entry
  } rc4_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/rc4_stream_cipher.sv
// RC4 stream cipher.
// Input channel (in_valid/in_ready) carries command, byte_in and last_key.
// command 0 loads a key byte, stored in order up to MAX_KEY_BYTES; extra bytes
// are dropped. The key byte flagged last_key starts the key schedule: it sets
// the identity permutation, then runs 256 swaps through the S_SCH_RI, S_SCH_RJ,
// S_SCH_WI and S_SCH_WJ states; in_ready stays low until the schedule ends.
// Other key bytes give no result and leave in_ready high.
// command 1 is a data byte. Once keyed, one keystream step runs through the
// S_KS_RJ, S_KS_WI and S_KS_WJ states; if the output slot is free, the result
// is loaded as it ends and in_ready returns at that same edge. No data byte is
// taken mid-step. The step is bound by the single write port of the permutation
// memory (two swap writes) behind two dependent reads. Before any key, data
// passes unchanged with not_keyed set and keystream 0; S_OUT loads the result.
// Output channel (out_valid/out_ready) is a register; an item is taken while a
// result still waits. If the receiver stalls, the next result parks in the
// block and in_ready stays low until the output slot frees.
// Reset (rst, synchronous) clears the key length, indices and keyed flag;
// the permutation and key store hold no defined value until written.
// Depends on rc4_pkg, rc4_ctrl and rc4_datapath.
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic [rc4_pkg::BYTE_W-1:0] byte_in,
  input  logic                       last_key,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rc4_pkg::BYTE_W-1:0] byte_out,
  output logic [rc4_pkg::BYTE_W-1:0] keystream_byte,
  output logic                       not_keyed
);
  import rc4_pkg::*;

  rc4_cmd_t    cmd;
  rc4_status_t status;

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .last_key  (last_key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rc4_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .byte_in        (byte_in),
    .byte_out       (byte_out),
    .keystream_byte (keystream_byte),
    .not_keyed      (not_keyed)
  );

endmodule

`default_nettype wire

// File: hw/rtl/rc4_datapath.sv
// RC4 datapath: permutation memory, key store, indices and output register.
// Driven by rc4_ctrl through rc4_pkg::rc4_cmd_t; depends on rc4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rc4_datapath #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rc4_pkg::rc4_cmd_t          cmd,
  output rc4_pkg::rc4_status_t       status,
  input  logic [rc4_pkg::BYTE_W-1:0] byte_in,
  output logic [rc4_pkg::BYTE_W-1:0] byte_out,
  output logic [rc4_pkg::BYTE_W-1:0] keystream_byte,
  output logic                       not_keyed
);
  import rc4_pkg::*;

  localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int LEN_W  = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_KEY_BYTES);

  // storage
  logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
  logic [BYTE_W-1:0] key_mem  [MAX_KEY_BYTES];

  // control state
  logic [LEN_W-1:0]  key_len;
  logic              keyed;
  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;
  logic [BYTE_W-1:0] idx_p;
  logic [KIDX_W-1:0] idx_k;

  // payload
  logic [BYTE_W-1:0] rd_a;
  logic [BYTE_W-1:0] rd_b;
  logic [BYTE_W-1:0] key_rd;
  logic [BYTE_W-1:0] si;
  logic [BYTE_W-1:0] sj;
  logic [BYTE_W-1:0] t_reg;
  logic [BYTE_W-1:0] byte_reg;
  logic [BYTE_W-1:0] ks_reg;
  logic              nk_reg;

  // combinational
  logic [BYTE_W-1:0] addr_a;
  logic [BYTE_W-1:0] addr_b;
  logic              we;
  logic [BYTE_W-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic [BYTE_W-1:0] sch_j;
  logic [BYTE_W-1:0] ks_j;
  logic [BYTE_W-1:0] ks_comb;
  logic              key_wr;
  logic              k_wrap;

  assign sch_j  = idx_j + rd_a + key_rd;
  assign ks_j   = idx_j + rd_a;
  assign key_wr = cmd.key_load && (key_len != LEN_MAX);
  assign k_wrap = (LEN_W'(idx_k) + LEN_W'(1)) == key_len;

  // Output entry: forward the swap writes that the registered read missed
  assign ks_comb = (t_reg == idx_j) ? si :
                   (t_reg == idx_i) ? sj : rd_b;

  assign status.keyed  = keyed;
  assign status.p_last = (idx_p == BYTE_W'(PERM_DEPTH - 1));

  // Memory port addressing
  always_comb begin
    addr_a = idx_p;
    addr_b = si + rd_a;
    we     = 1'b0;
    waddr  = idx_j;
    wdata  = si;
    if (cmd.sch_rd_j) addr_a = sch_j;
    if (cmd.ks_start) addr_a = idx_i + BYTE_W'(1);
    if (cmd.ks_rd_j)  addr_a = ks_j;
    if (cmd.init_wr) begin
      we    = 1'b1;
      waddr = idx_p;
      wdata = idx_p;
    end
    if (cmd.sch_wr_i) begin
      we    = 1'b1;
      waddr = idx_p;
      wdata = rd_a;
    end
    if (cmd.ks_wr_i) begin
      we    = 1'b1;
      waddr = idx_i;
      wdata = rd_a;
    end
    if (cmd.sch_wr_j || cmd.ks_wr_j) begin
      we    = 1'b1;
      waddr = idx_j;
      wdata = si;
    end
  end

  // Permutation memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) perm_mem[waddr] <= wdata;
    rd_a <= perm_mem[addr_a];
    rd_b <= perm_mem[addr_b];
  end

  // Key store
  always_ff @(posedge clk) begin
    if (key_wr) key_mem[key_len[KIDX_W-1:0]] <= byte_in;
    key_rd <= key_mem[idx_k];
  end

  // Indices, key length, keyed flag
  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= '0;
      keyed   <= 1'b0;
      idx_i   <= '0;
      idx_j   <= '0;
      idx_p   <= '0;
      idx_k   <= '0;
    end else begin
      if (key_wr) key_len <= key_len + LEN_W'(1);
      if (cmd.sched_begin) begin
        idx_j <= '0;
        idx_k <= '0;
        idx_p <= '0;
      end
      if (cmd.init_wr)  idx_p <= idx_p + BYTE_W'(1);
      if (cmd.sch_rd_j) idx_j <= sch_j;
      if (cmd.sch_wr_j) begin
        idx_p <= idx_p + BYTE_W'(1);
        idx_k <= k_wrap ? '0 : idx_k + KIDX_W'(1);
      end
      if (cmd.ks_start) idx_i <= idx_i + BYTE_W'(1);
      if (cmd.ks_rd_j)  idx_j <= ks_j;
      if (cmd.sched_done) begin
        idx_i   <= '0;
        idx_j   <= '0;
        keyed   <= 1'b1;
        key_len <= '0;
      end
    end
  end

  // Swap operands, data byte and output register
  always_ff @(posedge clk) begin
    if (cmd.sch_rd_j || cmd.ks_rd_j) si <= rd_a;
    if (cmd.ks_wr_i) begin
      sj    <= rd_a;
      t_reg <= si + rd_a;
    end
    if (cmd.ks_start) begin
      byte_reg <= byte_in;
      nk_reg   <= 1'b0;
    end
    if (cmd.pass_load) begin
      byte_reg <= byte_in;
      ks_reg   <= '0;
      nk_reg   <= 1'b1;
    end
    if (cmd.ks_hold) ks_reg <= ks_comb;
    if (cmd.out_load_ks) begin
      byte_out       <= byte_reg ^ ks_comb;
      keystream_byte <= ks_comb;
      not_keyed      <= 1'b0;
    end
    if (cmd.out_load_reg) begin
      byte_out       <= byte_reg ^ ks_reg;
      keystream_byte <= ks_reg;
      not_keyed      <= nk_reg;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rc4_ctrl.sv
// RC4 controller: sequences key loading, the key schedule and keystream steps.
// Issues rc4_pkg::rc4_cmd_t to rc4_datapath and owns the handshake flags.
`timescale 1ns / 1ps
`default_nettype none

module rc4_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic                 last_key,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rc4_pkg::rc4_status_t status,
  output rc4_pkg::rc4_cmd_t    cmd
);
  import rc4_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_SCH_RI = 4'd2;
  localparam logic [3:0] S_SCH_RJ = 4'd3;
  localparam logic [3:0] S_SCH_WI = 4'd4;
  localparam logic [3:0] S_SCH_WJ = 4'd5;
  localparam logic [3:0] S_KS_RJ  = 4'd6;
  localparam logic [3:0] S_KS_WI  = 4'd7;
  localparam logic [3:0] S_KS_WJ  = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  localparam logic CMD_KEY = 1'b0;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (command == CMD_KEY) begin
            cmd.key_load = 1'b1;
            if (last_key) begin
              cmd.sched_begin = 1'b1;
              state_next      = S_INIT;
            end
          end else if (status.keyed) begin
            cmd.ks_start = 1'b1;
            state_next   = S_KS_RJ;
          end else begin
            cmd.pass_load = 1'b1;
            state_next    = S_OUT;
          end
        end
      end
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (status.p_last) state_next = S_SCH_RI;
      end
      S_SCH_RI: state_next = S_SCH_RJ;
      S_SCH_RJ: begin
        cmd.sch_rd_j = 1'b1;
        state_next   = S_SCH_WI;
      end
      S_SCH_WI: begin
        cmd.sch_wr_i = 1'b1;
        state_next   = S_SCH_WJ;
      end
      S_SCH_WJ: begin
        cmd.sch_wr_j = 1'b1;
        if (status.p_last) begin
          cmd.sched_done = 1'b1;
          state_next     = S_IDLE;
        end else begin
          state_next = S_SCH_RI;
        end
      end
      S_KS_RJ: begin
        cmd.ks_rd_j = 1'b1;
        state_next  = S_KS_WI;
      end
      S_KS_WI: begin
        cmd.ks_wr_i = 1'b1;
        state_next  = S_KS_WJ;
      end
      S_KS_WJ: begin
        cmd.ks_wr_j = 1'b1;
        if (slot_free) begin
          cmd.out_load_ks = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.ks_hold = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load_reg = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load_ks || cmd.out_load_reg) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rc4_checker.sv
// Port-level checks for rc4_stream_cipher, attached by bind.
// Sees only the top-level ports; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module rc4_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       command,
  input logic       last_key,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] byte_out,
  input logic [7:0] keystream_byte,
  input logic       not_keyed
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_out) &&
      $stable(keystream_byte) && $stable(not_keyed))
    else $error("result changed while stalled");

  // unkeyed results carry no keystream
  a_unkeyed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && not_keyed |-> keystream_byte == 8'h00)
    else $error("unkeyed result with nonzero keystream");

  // last key byte starts the schedule, input closes for a while
  a_sched_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !command && last_key |=> !in_ready ##1 !in_ready)
    else $error("input open during key schedule");

  // a data transfer closes the input in the following cycle
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command |=> !in_ready)
    else $error("input open right after a data transfer");

  // a plain key byte gives no result and leaves input open
  a_key_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !command && !last_key && !out_valid |=>
      !out_valid && in_ready)
    else $error("key byte produced a result or stalled");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);

`default_nettype wire

// File: bench/rc4_tb_pkg.sv
// Command codes shared by the RC4 cipher bench files.
// Used by rc4_scoreboard and tb_rc4_stream_cipher; no other dependencies.
`timescale 1ns / 1ps

package rc4_tb_pkg;

  localparam logic CMD_KEY  = 1'b0;  // key byte for the key store
  localparam logic CMD_DATA = 1'b1;  // data byte for the keystream XOR

endpackage

// File: bench/rc4_checker.sv
// Scoreboard for rc4_stream_cipher: tracks the permutation, key store and indices
// on every input transfer and checks every output transfer in order.
// Depends on rc4_pkg (widths, depth) and rc4_tb_pkg (command codes).
`timescale 1ns / 1ps

module rc4_scoreboard #(
  parameter int KEY_LIMIT = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       command,
  input  logic [rc4_pkg::BYTE_W-1:0] byte_in,
  input  logic                       last_key,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [rc4_pkg::BYTE_W-1:0] byte_out,
  input  logic [rc4_pkg::BYTE_W-1:0] keystream_byte,
  input  logic                       not_keyed,
  output int                         fail_count,
  output int                         pending_count,
  output int                         results_checked,
  output int                         schedules_run
);
  import rc4_pkg::*;
  import rc4_tb_pkg::*;

  localparam int STORE_LIMIT = (KEY_LIMIT > PERM_DEPTH) ? PERM_DEPTH :
                               (KEY_LIMIT < 1) ? 1 : KEY_LIMIT;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] stream;
    logic              bare;
  } cipher_out_t;

  // Shadow cipher state
  logic [BYTE_W-1:0] sbox      [PERM_DEPTH];
  logic [BYTE_W-1:0] key_bytes [PERM_DEPTH];
  int                key_count;
  logic [BYTE_W-1:0] ptr_i;
  logic [BYTE_W-1:0] ptr_j;
  logic              is_keyed;
  cipher_out_t       cipher_q[$];
  int                fails;
  int                checked;
  int                schedules;

  function automatic void swap_entries(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] tmp;
    tmp     = sbox[a];
    sbox[a] = sbox[b];
    sbox[b] = tmp;
  endfunction

  // Key schedule over the bytes loaded for the current key
  function automatic void schedule_key();
    int                span;
    logic [BYTE_W-1:0] run;
    span = (key_count == 0) ? 1 : key_count;
    for (int p = 0; p < PERM_DEPTH; p++) sbox[p] = p[BYTE_W-1:0];
    run = '0;
    for (int p = 0; p < PERM_DEPTH; p++) begin
      run = run + sbox[p] + key_bytes[p % span];
      swap_entries(p[BYTE_W-1:0], run);
    end
    ptr_i    = '0;
    ptr_j    = '0;
    is_keyed = 1'b1;
  endfunction

  // One keystream step; returns the keystream byte
  function automatic logic [BYTE_W-1:0] next_stream_byte();
    logic [BYTE_W-1:0] sum;
    ptr_i = ptr_i + 8'd1;
    ptr_j = ptr_j + sbox[ptr_i];
    swap_entries(ptr_i, ptr_j);
    sum = sbox[ptr_i] + sbox[ptr_j];
    return sbox[sum];
  endfunction

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    cipher_out_t       want;
    logic [BYTE_W-1:0] ks;
    if (rst) begin
      key_count = 0;
      ptr_i     = '0;
      ptr_j     = '0;
      is_keyed  = 1'b0;
      cipher_q.delete();
      fails     = 0;
      checked   = 0;
      schedules = 0;
    end else begin
      // Output transfer: compare against the oldest expectation
      if (out_valid === 1'b1 && out_ready) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected output, expected none, got byte_out %h keystream %h",
                   $time, byte_out, keystream_byte);
          fails++;
        end else begin
          want = cipher_q.pop_front();
          check_field("byte_out", want.data, byte_out);
          check_field("keystream_byte", want.stream, keystream_byte);
          check_field("not_keyed", {7'd0, want.bare}, {7'd0, not_keyed});
          checked++;
        end
      end
      // Input transfer: update shadow state, queue the expected result
      if (in_valid && in_ready === 1'b1) begin
        if (command == CMD_KEY) begin
          if (key_count < STORE_LIMIT) begin
            key_bytes[key_count] = byte_in;
            key_count++;
          end
          if (last_key) begin
            schedule_key();
            key_count = 0;
            schedules++;
          end
        end else if (!is_keyed) begin
          want.data   = byte_in;
          want.stream = '0;
          want.bare   = 1'b1;
          cipher_q.push_back(want);
        end else begin
          ks          = next_stream_byte();
          want.data   = byte_in ^ ks;
          want.stream = ks;
          want.bare   = 1'b0;
          cipher_q.push_back(want);
        end
      end
    end
    fail_count      <= fails;
    pending_count   <= cipher_q.size();
    results_checked <= checked;
    schedules_run   <= schedules;
  end

endmodule

// File: bench/tb_rc4_stream_cipher.sv
// Top of the rc4_stream_cipher bench: clock, reset, stimulus, output stalls and verdict.
// Depends on rc4_pkg, rc4_tb_pkg, rc4_scoreboard and the rc4_stream_cipher RTL.
`timescale 1ns / 1ps

module tb_rc4_stream_cipher;
  import rc4_pkg::*;
  import rc4_tb_pkg::*;

  localparam int KEY_DEPTH   = 256;
  localparam int ITEM_TARGET = 1350;
  localparam int STALL_LIMIT = 5000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              command = CMD_KEY;
  logic [BYTE_W-1:0] byte_in = '0;
  logic              last_key = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] byte_out;
  logic [BYTE_W-1:0] keystream_byte;
  logic              not_keyed;

  logic steady = 1'b0;  // no idling on either side while set
  int   sent;
  int   fail_count;
  int   pending_count;
  int   results_checked;
  int   schedules_run;
  int   quiet_cycles;

  rc4_stream_cipher #(.MAX_KEY_BYTES(KEY_DEPTH)) uut (
    .clk, .rst, .in_valid, .in_ready, .command, .byte_in, .last_key,
    .out_valid, .out_ready, .byte_out, .keystream_byte, .not_keyed
  );

  rc4_scoreboard #(.KEY_LIMIT(KEY_DEPTH)) u_scoreboard (
    .clk, .rst, .in_valid, .in_ready, .command, .byte_in, .last_key,
    .out_valid, .out_ready, .byte_out, .keystream_byte, .not_keyed,
    .fail_count, .pending_count, .results_checked, .schedules_run
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls outside the steady window
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 33);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b, input logic lk);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    byte_in  <= b;
    last_key <= lk;
    do @(posedge clk); while (in_ready !== 1'b1);
    sent++;
  endtask

  task automatic send_data_burst(input int count);
    repeat (count) send_item(CMD_DATA, BYTE_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
  endtask

  // Key of len bytes, optionally with data transfers in the middle of loading
  task automatic load_key(input int len, input bit with_data);
    int split;
    split = with_data ? $urandom_range(0, len - 1) : -1;
    for (int n = 0; n < len; n++) begin
      if (n == split) send_data_burst($urandom_range(1, 6));
      send_item(CMD_KEY, BYTE_W'($urandom_range(0, 255)), n == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    int  pick;
    int  len;
    bit  full_key_done;
    bit  long_key_done;
    bit  drained_once;
    sent          = 0;
    full_key_done = 1'b0;
    long_key_done = 1'b0;
    drained_once  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Data before any key passes through untouched
    send_item(CMD_DATA, 8'h00, 1'b0);
    send_item(CMD_DATA, 8'hFF, 1'b1);
    send_item(CMD_DATA, 8'h5A, 1'b0);
    // Single zero key byte
    send_item(CMD_KEY, 8'h00, 1'b1);
    send_item(CMD_DATA, 8'h00, 1'b0);
    send_item(CMD_DATA, 8'hFF, 1'b0);
    send_item(CMD_DATA, 8'hA5, 1'b1);
    send_item(CMD_DATA, 8'h3C, 1'b0);
    // Textbook three-byte key
    send_item(CMD_KEY, 8'h4B, 1'b0);
    send_item(CMD_KEY, 8'h65, 1'b0);
    send_item(CMD_KEY, 8'h79, 1'b1);
    send_item(CMD_DATA, 8'h50, 1'b0);
    send_item(CMD_DATA, 8'h6C, 1'b0);
    send_item(CMD_DATA, 8'h61, 1'b0);
    send_item(CMD_DATA, 8'h69, 1'b0);
    // Partial new key while the old keystream keeps running
    send_item(CMD_KEY, 8'hFF, 1'b0);
    send_item(CMD_DATA, 8'h6E, 1'b1);
    send_item(CMD_DATA, 8'h74, 1'b1);
    send_item(CMD_KEY, 8'h80, 1'b1);
    send_item(CMD_DATA, 8'h01, 1'b0);
    send_item(CMD_DATA, 8'hFE, 1'b0);

    // Random part: mostly data bursts, new keys of mixed length now and then
    while (sent < ITEM_TARGET) begin
      if (!full_key_done && sent > 400) begin
        load_key(KEY_DEPTH, 1'b0);
        full_key_done = 1'b1;
      end else if (!long_key_done && sent > 900) begin
        load_key(KEY_DEPTH + $urandom_range(1, 60), 1'b1);
        long_key_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          pick = $urandom_range(0, 99);
          len  = (pick < 70) ? $urandom_range(1, 16) :
                 (pick < 95) ? $urandom_range(17, 64) : $urandom_range(65, KEY_DEPTH);
          load_key(len, $urandom_range(0, 99) < 30);
        end else if (pick < 14) begin
          // stray key bytes become the head of the next key
          repeat ($urandom_range(1, 3))
            send_item(CMD_KEY, BYTE_W'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_data_burst($urandom_range(1, 40));
        end
      end
      if (!drained_once && sent > 1050) begin
        wait_drained();
        drained_once = 1'b1;
      end
      steady <= (sent >= 600 && sent < 800);
    end

    steady <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    $display("summary: %0d input transfers, %0d results checked, %0d key schedules",
             sent, results_checked, schedules_run);
    $display("summary: keys from 1 byte to past the store depth, pre-key passthrough");
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_datapath.sv
hw/rtl/rc4_ctrl.sv
hw/rtl/rc4_stream_cipher.sv
hw/rtl/rc4_checker.sv
bench/rc4_tb_pkg.sv
bench/rc4_checker.sv
bench/tb_rc4_stream_cipher.sv
